FILE: sv/codel_queue_manager_unit_macros.svh
// Assertion helpers for the CoDel queue manager.
`ifndef CODEL_QUEUE_MANAGER_UNIT_MACROS_SVH
`define CODEL_QUEUE_MANAGER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CQM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CQM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CQM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CQM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/cqm_pkg.sv
`timescale 1ns / 1ps
package cqm_pkg;

  localparam int CQM_CAPACITY = 128;
  localparam int CQM_IDX_W    = $clog2(CQM_CAPACITY);
  localparam int CQM_CNT_W    = $clog2(CQM_CAPACITY + 1);
  localparam int CQM_ENTRY_W  = 48;
  localparam int CQM_Q_W      = 20;
  localparam int CQM_BIT_W    = $clog2(CQM_Q_W);
  localparam int CQM_SQ_W     = 2 * CQM_Q_W;
  localparam int CQM_PROD_W   = CQM_SQ_W + CQM_Q_W;

  localparam logic [1:0] REG_TARGET   = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_MINLEN   = 2'd2;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [2:0] {
    ST_ENQUEUED  = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_FORWARDED = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] packet_size;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_size;
    logic [31:0] sojourn;
    logic [7:0]  queue_length;
    logic [31:0] total_dropped;
  } out_item_t;

endpackage

FILE: sv/codel_queue_manager_unit.sv
`timescale 1ns / 1ps
// CoDel queue manager: packet FIFO with controlled-delay drop decisions.
// Input: a request is taken on a clock edge with start high and busy low;
// in_item carries req_type (enqueue/dequeue), packet_size and now.
// Output: one result per request, shown on out_result for exactly one cycle
// with out_strobe high; the receiver must take it then.
// Config: cfg_valid/cfg_ready writes target delay (0), drop interval (1) and
// minimum queue length (2); write only while busy is low.
// Enqueue and empty dequeue pass through S_EXEC; a dequeue that finds a packet also S_DECIDE.
// A control-law drop adds floor(interval/sqrt(count)) through one shared
// 40x20 multiplier: setup steps S_LIM and S_SET, then S_MUL and S_CMP for
// each bit of the 20-bit result. busy stays high until the result strobe.
// Packet entries sit in a single-port-write, registered-read RAM.
// Reset (synchronous, rst_n low) empties the queue, clears the drop state
// and tally and loads the default config (5, 100, 4).
module codel_queue_manager_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cqm_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output cqm_pkg::out_item_t out_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  localparam int CmpW = (cqm_pkg::CQM_CNT_W > 8) ? cqm_pkg::CQM_CNT_W : 8;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_LIM    = 7'b0001000,
    S_SET    = 7'b0010000,
    S_MUL    = 7'b0100000,
    S_CMP    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  cqm_pkg::in_item_t  item_r, item_nxt;
  cqm_pkg::out_item_t res_r, res_nxt;
  logic out_strobe_r, out_strobe_nxt;

  logic [cqm_pkg::CQM_IDX_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [cqm_pkg::CQM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic        above_r, above_nxt, armed_r, armed_nxt;
  logic [31:0] ndt_r, ndt_nxt, tally_r, tally_nxt, soj_r, soj_nxt;
  logic [15:0] drc_r, drc_nxt;
  logic [19:0] tgt_r, tgt_nxt, ival_r, ival_nxt;
  logic [7:0]  minlen_r, minlen_nxt;

  logic [cqm_pkg::CQM_Q_W-1:0]    q_r, q_nxt;
  logic [cqm_pkg::CQM_SQ_W-1:0]   q2_r, q2_nxt, t2_r, t2_nxt, lim_r, lim_nxt;
  logic [cqm_pkg::CQM_BIT_W-1:0]  bit_r, bit_nxt;
  logic [cqm_pkg::CQM_PROD_W-1:0] prod_r, prod_nxt;
  logic [cqm_pkg::CQM_SQ_W-1:0]   mul_a;
  logic [cqm_pkg::CQM_Q_W-1:0]    mul_b;

  logic                              ram_we, ram_re;
  logic [cqm_pkg::CQM_ENTRY_W-1:0]   ram_rdata;

  logic [31:0] arr_time, diff;
  logic [15:0] head_size;
  logic        full, low_delay, short_q, due, ok;
  logic [cqm_pkg::CQM_SQ_W-1:0] trial2;
  logic [cqm_pkg::CQM_Q_W-1:0]  bit_mask, q_new;

  cqm_ram #(
    .WIDTH(cqm_pkg::CQM_ENTRY_W),
    .DEPTH(cqm_pkg::CQM_CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_r),
    .wdata({item_r.packet_size, item_r.now}),
    .re   (ram_re),
    .raddr(head_r),
    .rdata(ram_rdata)
  );

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_result = res_r;

  assign head_size = ram_rdata[47:32];
  assign arr_time  = ram_rdata[31:0];
  assign full      = (cnt_r == cqm_pkg::CQM_CNT_W'(cqm_pkg::CQM_CAPACITY));
  assign low_delay = soj_r[31] | (soj_r < 32'(tgt_r));
  assign short_q   = (CmpW'(cnt_r) <= CmpW'(minlen_r));
  assign diff      = item_r.now - ndt_r;
  assign due       = armed_r & ~diff[31];

  assign bit_mask = cqm_pkg::CQM_Q_W'(1) << bit_r;
  assign trial2   = q2_r
                  + (cqm_pkg::CQM_SQ_W'(q_r) << ({1'b0, bit_r} + 6'd1))
                  + (cqm_pkg::CQM_SQ_W'(1) << {bit_r, 1'b0});
  assign ok       = (prod_r <= cqm_pkg::CQM_PROD_W'(lim_r));
  assign q_new    = ok ? (q_r | bit_mask) : q_r;
  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    res_nxt    = res_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    above_nxt  = above_r;
    armed_nxt  = armed_r;
    ndt_nxt    = ndt_r;
    tally_nxt  = tally_r;
    soj_nxt    = soj_r;
    drc_nxt    = drc_r;
    tgt_nxt    = tgt_r;
    ival_nxt   = ival_r;
    minlen_nxt = minlen_r;
    q_nxt      = q_r;
    q2_nxt     = q2_r;
    t2_nxt     = t2_r;
    lim_nxt    = lim_r;
    bit_nxt    = bit_r;
    mul_a      = '0;
    mul_b      = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cqm_pkg::REG_TARGET:   tgt_nxt    = cfg_data;
        cqm_pkg::REG_INTERVAL: ival_nxt   = cfg_data;
        cqm_pkg::REG_MINLEN:   minlen_nxt = cfg_data[7:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          ram_re    = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt.out_size = '0;
        res_nxt.sojourn  = '0;
        if (item_r.req_type == cqm_pkg::REQ_ENQ) begin
          if (full) begin
            tally_nxt      = tally_r + 32'd1;
            res_nxt.status = cqm_pkg::ST_REJECTED;
          end else begin
            ram_we         = 1'b1;
            tail_nxt       = (tail_r == cqm_pkg::CQM_IDX_W'(cqm_pkg::CQM_CAPACITY - 1))
                           ? '0 : tail_r + cqm_pkg::CQM_IDX_W'(1);
            cnt_nxt        = cnt_r + cqm_pkg::CQM_CNT_W'(1);
            res_nxt.status = cqm_pkg::ST_ENQUEUED;
          end
          res_nxt.queue_length  = 8'(cnt_nxt);
          res_nxt.total_dropped = tally_nxt;
          state_nxt             = S_IDLE;
        end else if (cnt_r == '0) begin
          res_nxt.status        = cqm_pkg::ST_EMPTY;
          res_nxt.queue_length  = 8'(cnt_r);
          res_nxt.total_dropped = tally_r;
          state_nxt             = S_IDLE;
        end else begin
          soj_nxt   = item_r.now - arr_time;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        head_nxt = (head_r == cqm_pkg::CQM_IDX_W'(cqm_pkg::CQM_CAPACITY - 1))
                 ? '0 : head_r + cqm_pkg::CQM_IDX_W'(1);
        cnt_nxt  = cnt_r - cqm_pkg::CQM_CNT_W'(1);
        res_nxt.status   = cqm_pkg::ST_FORWARDED;
        state_nxt        = S_IDLE;
        if (low_delay || short_q) begin
          above_nxt = 1'b0;
          armed_nxt = 1'b0;
          drc_nxt   = '0;
        end else if (!above_r) begin
          above_nxt = 1'b1;
          armed_nxt = 1'b1;
          ndt_nxt   = item_r.now + 32'(ival_r);
        end else if (due) begin
          res_nxt.status = cqm_pkg::ST_DROPPED;
          tally_nxt      = tally_r + 32'd1;
          drc_nxt        = (drc_r == 16'hFFFF) ? drc_r : drc_r + 16'd1;
          state_nxt      = S_LIM;
        end else begin
          drc_nxt = '0;
        end
        res_nxt.out_size      = head_size;
        res_nxt.sojourn       = soj_r;
        res_nxt.queue_length  = 8'(cnt_nxt);
        res_nxt.total_dropped = tally_nxt;
      end
      S_LIM: begin
        mul_a     = cqm_pkg::CQM_SQ_W'(ival_r);
        mul_b     = ival_r;
        state_nxt = S_SET;
      end
      S_SET: begin
        lim_nxt   = prod_r[cqm_pkg::CQM_SQ_W-1:0];
        q_nxt     = '0;
        q2_nxt    = '0;
        bit_nxt   = cqm_pkg::CQM_BIT_W'(cqm_pkg::CQM_Q_W - 1);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        mul_a     = trial2;
        mul_b     = cqm_pkg::CQM_Q_W'(drc_r);
        t2_nxt    = trial2;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        q_nxt = q_new;
        if (ok) begin
          q2_nxt = t2_r;
        end
        if (bit_r == '0) begin
          ndt_nxt   = item_r.now + 32'(q_new);
          state_nxt = S_IDLE;
        end else begin
          bit_nxt   = bit_r - cqm_pkg::CQM_BIT_W'(1);
          state_nxt = S_MUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_strobe_nxt = (state_nxt == S_IDLE) && (state_r != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      above_r      <= 1'b0;
      armed_r      <= 1'b0;
      ndt_r        <= '0;
      drc_r        <= '0;
      tally_r      <= '0;
      tgt_r        <= 20'd5;
      ival_r       <= 20'd100;
      minlen_r     <= 8'd4;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cnt_r        <= cnt_nxt;
      above_r      <= above_nxt;
      armed_r      <= armed_nxt;
      ndt_r        <= ndt_nxt;
      drc_r        <= drc_nxt;
      tally_r      <= tally_nxt;
      tgt_r        <= tgt_nxt;
      ival_r       <= ival_nxt;
      minlen_r     <= minlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    soj_r  <= soj_nxt;
    q_r    <= q_nxt;
    q2_r   <= q2_nxt;
    t2_r   <= t2_nxt;
    lim_r  <= lim_nxt;
    bit_r  <= bit_nxt;
    prod_r <= prod_nxt;
  end

`include "codel_queue_manager_unit_macros.svh"

  `CQM_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `CQM_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)
  `CQM_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `CQM_ASSERT_SAME(a_cnt_range, clk, rst_n, 1'b1,
                   cnt_r <= cqm_pkg::CQM_CNT_W'(cqm_pkg::CQM_CAPACITY))

endmodule

FILE: sv/cqm_ram.sv
`timescale 1ns / 1ps
module cqm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import cqm_pkg::*;

  localparam int DEPTH          = CQM_CAPACITY;
  localparam int WATCHDOG_LIMIT = 2000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      start     = 1'b0;
  logic      busy;
  in_item_t  in_item   = '0;
  logic      out_strobe;
  out_item_t out_result;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = REG_TARGET;
  logic [19:0] cfg_data  = '0;

  codel_queue_manager_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // queue state mirror
  logic [15:0] q_size    [DEPTH];
  logic [31:0] q_arrival [DEPTH];
  int unsigned q_head, q_tail, q_held;
  bit          above_target, drop_armed;
  logic [31:0] next_drop_time;
  logic [15:0] drop_run;
  logic [31:0] drop_tally;
  logic [19:0] target_delay, drop_interval;
  logic [7:0]  min_len;

  out_item_t   pending_results[$];
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  logic [31:0] tick;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_queue_state();
    q_head         = 0;
    q_tail         = 0;
    q_held         = 0;
    above_target   = 1'b0;
    drop_armed     = 1'b0;
    next_drop_time = '0;
    drop_run       = '0;
    drop_tally     = '0;
    target_delay   = 20'd5;
    drop_interval  = 20'd100;
    min_len        = 8'd4;
  endfunction

  // largest q <= ival with q*q*cnt <= ival*ival
  function automatic logic [31:0] spaced_interval(logic [19:0] ival, logic [15:0] cnt);
    longint unsigned lim, sq, lo, hi, mid;
    if (cnt == 0) return 32'(ival);
    lim = longint'(ival) * longint'(ival);
    lo  = 0;
    hi  = 64'(ival);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      sq  = mid * mid * longint'(cnt);
      if (sq <= lim) lo = mid;
      else hi = mid - 1;
    end
    return lo[31:0];
  endfunction

  function automatic out_item_t codel_predict(in_item_t it);
    out_item_t   r;
    int unsigned len_before;
    int          signed_sojourn, past_drop;
    r = '0;
    if (it.req_type == REQ_ENQ) begin
      if (q_held >= DEPTH) begin
        r.status = ST_REJECTED;
        drop_tally++;
      end else begin
        q_size[q_tail]    = it.packet_size;
        q_arrival[q_tail] = it.now;
        q_tail = (q_tail + 1) % DEPTH;
        q_held++;
        r.status = ST_ENQUEUED;
      end
    end else if (q_held == 0) begin
      r.status = ST_EMPTY;
    end else begin
      len_before = q_held;
      r.out_size = q_size[q_head];
      r.sojourn  = it.now - q_arrival[q_head];
      q_head = (q_head + 1) % DEPTH;
      q_held--;
      signed_sojourn = r.sojourn;
      past_drop      = it.now - next_drop_time;
      if (signed_sojourn < int'(target_delay) || len_before <= min_len) begin
        above_target = 1'b0;
        drop_armed   = 1'b0;
        drop_run     = '0;
        r.status     = ST_FORWARDED;
      end else if (!above_target) begin
        above_target   = 1'b1;
        drop_armed     = 1'b1;
        next_drop_time = it.now + drop_interval;
        r.status       = ST_FORWARDED;
      end else if (drop_armed && past_drop >= 0) begin
        r.status = ST_DROPPED;
        drop_tally++;
        if (drop_run != 16'hFFFF) drop_run++;
        next_drop_time = it.now + spaced_interval(drop_interval, drop_run);
      end else begin
        drop_run = '0;
        r.status = ST_FORWARDED;
      end
    end
    r.queue_length  = q_held[7:0];
    r.total_dropped = drop_tally;
    return r;
  endfunction

  function automatic in_item_t make_request(logic req, logic [15:0] size, logic [31:0] now);
    in_item_t it;
    it.req_type    = req;
    it.packet_size = size;
    it.now         = now;
    return it;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // start stays high after a transfer; the caller either sends again or lowers it
  task automatic send_request(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(codel_predict(it));
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_gapped(input in_item_t it, input bit quiet);
    int gap;
    send_request(it);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) hold_off(gap);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_config(input logic [19:0] tgt, input logic [19:0] ival,
                            input logic [7:0] minlen);
    logic [1:0]  reg_ids  [3];
    logic [19:0] reg_vals [3];
    reg_ids[0]  = REG_TARGET;
    reg_ids[1]  = REG_INTERVAL;
    reg_ids[2]  = REG_MINLEN;
    reg_vals[0] = tgt;
    reg_vals[1] = ival;
    reg_vals[2] = {12'd0, minlen};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index <= reg_ids[k];
      cfg_data  <= reg_vals[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      case (reg_ids[k])
        REG_TARGET:   target_delay  = reg_vals[k];
        REG_INTERVAL: drop_interval = reg_vals[k];
        REG_MINLEN:   min_len       = reg_vals[k][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_and_extremes();
    send_gapped(make_request(REQ_DEQ, 16'h0000, 32'h0000_0000), 1'b0);
    send_gapped(make_request(REQ_ENQ, 16'hFFFF, 32'hFFFF_FFF0), 1'b0);
    send_gapped(make_request(REQ_ENQ, 16'h0000, 32'h0000_0005), 1'b0);
    send_gapped(make_request(REQ_DEQ, 16'h1234, 32'h0000_0010), 1'b0);
    send_gapped(make_request(REQ_DEQ, 16'h0000, 32'h8000_0000), 1'b0);
    send_gapped(make_request(REQ_DEQ, 16'hFFFF, 32'hFFFF_FFFF), 1'b0);
  endtask

  task automatic test_control_law();
    logic [15:0] sizes [5];
    logic [31:0] deq_times [5];
    sizes     = '{16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 16'h8001};
    deq_times = '{32'd1000, 32'd1050, 32'd1060, 32'd1070, 32'd1090};
    wait_idle();
    set_config(20'd10, 20'd16, 8'd0);
    foreach (sizes[k]) send_gapped(make_request(REQ_ENQ, sizes[k], 32'd1000), 1'b0);
    // below target, first high sojourn, before drop time, drop, second drop
    foreach (deq_times[k]) send_gapped(make_request(REQ_DEQ, 16'd0, deq_times[k]), 1'b0);
    // arrival stamped in the future: negative sojourn passes as below target
    send_gapped(make_request(REQ_ENQ, 16'h00FF, 32'd5000), 1'b0);
    send_gapped(make_request(REQ_ENQ, 16'hFF00, 32'd5000), 1'b0);
    send_gapped(make_request(REQ_DEQ, 16'd0, 32'd4000), 1'b0);
    send_gapped(make_request(REQ_DEQ, 16'd0, 32'd5000), 1'b0);
    // zero interval: drop time lands on now
    wait_idle();
    set_config(20'd0, 20'd0, 8'd0);
    repeat (3) send_gapped(make_request(REQ_ENQ, 16'($urandom()), 32'd200), 1'b0);
    repeat (3) send_gapped(make_request(REQ_DEQ, 16'd0, 32'd300), 1'b0);
  endtask

  task automatic test_overflow();
    wait_idle();
    set_config(20'd30, 20'd50, 8'd16);
    tick = 32'hFFFF_F000;
    while (q_held < DEPTH) begin
      tick += $urandom_range(0, 3);
      send_gapped(make_request(REQ_ENQ, 16'($urandom()), tick), 1'b0);
    end
    repeat (3) send_gapped(make_request(REQ_ENQ, 16'($urandom()), tick), 1'b0);
    wait_idle();
    while (q_held > 0) begin
      tick += $urandom_range(0, 20);
      send_gapped(make_request(REQ_DEQ, 16'($urandom()), tick), 1'b0);
    end
    send_gapped(make_request(REQ_DEQ, 16'($urandom()), tick), 1'b0);
  endtask

  task automatic test_random_traffic(input logic [19:0] tgt, input logic [19:0] ival,
                                     input logic [7:0] minlen, input int count,
                                     input bit quiet);
    in_item_t    it;
    int unsigned level, roll, step_max;
    wait_idle();
    set_config(tgt, ival, minlen);
    step_max = (int'(tgt) + int'(ival)) / 3 + 2;
    tick     = $urandom();
    level    = minlen + 6;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 15) == 0) level = $urandom_range(0, minlen + 12);
      roll = $urandom_range(0, 99);
      if (q_held < level) it.req_type = (roll < 75) ? REQ_ENQ : REQ_DEQ;
      else it.req_type = (roll < 75) ? REQ_DEQ : REQ_ENQ;
      it.packet_size = 16'($urandom());
      tick += $urandom_range(0, step_max);
      it.now = tick;
      roll = $urandom_range(0, 99);
      if (roll < 3) it.now = $urandom();
      else if (roll < 6) it.now = tick - $urandom_range(1, step_max + 1);
      if (!quiet && $urandom_range(0, 99) == 0) wait_idle();
      send_gapped(it, quiet);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: status %0d size %h sojourn %h len %0d dropped %0d",
                   out_result.status, out_result.out_size, out_result.sojourn,
                   out_result.queue_length, out_result.total_dropped);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_result.status !== want.status || out_result.out_size !== want.out_size ||
            out_result.sojourn !== want.sojourn ||
            out_result.queue_length !== want.queue_length ||
            out_result.total_dropped !== want.total_dropped) begin
          if (mismatch_count < 10) begin
            $display("mismatch exp: status %0d size %h sojourn %h len %0d dropped %0d",
                     want.status, want.out_size, want.sojourn, want.queue_length,
                     want.total_dropped);
            $display("         got: status %0d size %h sojourn %h len %0d dropped %0d",
                     out_result.status, out_result.out_size, out_result.sojourn,
                     out_result.queue_length, out_result.total_dropped);
          end
          mismatch_count++;
        end
      end
    end
  end

  // any transfer counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("codel_queue_manager_unit test failed");
    $finish;
  end

  initial begin
    clear_queue_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_extremes();
    test_control_law();
    test_overflow();
    test_random_traffic(20'd5, 20'd100, 8'd4, 78, 1'b0);
    test_random_traffic(20'd0, 20'd1, 8'd0, 78, 1'b0);
    test_random_traffic(20'hFFFFF, 20'hFFFFF, 8'd128, 78, 1'b0);
    test_random_traffic(20'($urandom_range(0, 60)), 20'($urandom_range(1, 400)),
                        8'($urandom_range(0, 8)), 78, 1'b1);
    test_random_traffic(20'd2, 20'd0, 8'd1, 78, 1'b0);
    test_random_traffic(20'($urandom()), 20'($urandom()), 8'($urandom_range(0, 128)),
                        78, 1'b0);
    wait_idle();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("codel_queue_manager_unit test passed");
    end else begin
      $display("codel_queue_manager_unit test failed");
    end
    $finish;
  end

endmodule
